FILE: design/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg: shared definitions for the integer to radix digits block
// Widths, base limits, character codes, back end states and the queue control
// word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int BASE_W         = 6;
  localparam int CHAR_W         = 7;
  localparam int DIGIT_W        = 6;
  localparam int STEP_BITS      = 8;

  localparam logic [BASE_W-1:0] RADIX_MIN    = 6'd2;
  localparam logic [BASE_W-1:0] RADIX_MAX    = 6'd36;
  localparam logic [BASE_W-1:0] SIGNED_RADIX = 6'd10;

  localparam logic [CHAR_W-1:0] MINUS_CODE   = 7'h2D;
  localparam logic [CHAR_W-1:0] INVALID_CODE = 7'h00;
  localparam logic [CHAR_W-1:0] ZERO_CODE    = 7'h30;
  localparam logic [CHAR_W-1:0] ALPHA_OFFSET = 7'h57;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic              bad;
    logic              neg;
    logic [BASE_W-1:0] base;
  } q_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DEC_DIGITS) begin
      return ZERO_CODE + dx;
    end else begin
      return ALPHA_OFFSET + dx;
    end
  endfunction

endpackage

FILE: design/itrd_if.sv
// ----------------------------------------------------------------------------
// itrd_in_if / itrd_out_if: valid/ready channels of the digit converter
// The input channel carries one conversion request, the output channel one
// character of the result.
// ----------------------------------------------------------------------------
interface itrd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [itrd_pkg::VALUE_W-1:0] value;
  logic [itrd_pkg::BASE_W-1:0]  base;

  modport source (output valid, output op, output value, output base, input ready);
  modport sink   (input valid, input op, input value, input base, output ready);
endinterface

interface itrd_out_if;
  logic                        valid;
  logic                        ready;
  logic [itrd_pkg::CHAR_W-1:0] char_code;
  logic                        last;
  logic                        bad_base;

  modport source (output valid, output char_code, output last, output bad_base,
                  input ready);
  modport sink   (input valid, input char_code, input last, input bad_base,
                  output ready);
endinterface

FILE: design/itrd_front.sv
// ----------------------------------------------------------------------------
// itrd_front: request intake and classification
// Checks the base, finds the sign in signed decimal mode, forms the magnitude
// and holds up to two classified requests for the back end.
// ----------------------------------------------------------------------------
module itrd_front #(
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    in_op_i,
  input  logic [itrd_pkg::VALUE_W-1:0] in_value_i,
  input  logic [itrd_pkg::BASE_W-1:0]  in_base_i,
  output logic                    q_valid_o,
  input  logic                    q_ready_i,
  output itrd_pkg::q_ctrl_t       q_ctrl_o,
  output logic [VALUE_BITS-1:0]   q_mag_o
);

  localparam int IN_USE = (VALUE_BITS < itrd_pkg::VALUE_W) ? VALUE_BITS
                                                           : itrd_pkg::VALUE_W;

  logic [VALUE_BITS-1:0] val;
  logic [VALUE_BITS-1:0] mag;
  itrd_pkg::q_ctrl_t     ctrl;

  itrd_pkg::q_ctrl_t     ctrl_q [2];
  logic [VALUE_BITS-1:0] mag_q  [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            count_q;
  logic                  push, pop;

  always_comb begin
    val       = VALUE_BITS'(in_value_i[IN_USE-1:0]);
    ctrl.base = in_base_i;
    ctrl.bad  = (in_base_i < itrd_pkg::RADIX_MIN) || (in_base_i > itrd_pkg::RADIX_MAX);
    ctrl.neg  = in_op_i && (in_base_i == itrd_pkg::SIGNED_RADIX) && val[VALUE_BITS-1];
    mag       = ctrl.neg ? (~val + VALUE_BITS'(1)) : val;
  end

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;
  assign q_ctrl_o   = ctrl_q[rd_ptr_q];
  assign q_mag_o    = mag_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctrl_q[wr_ptr_q] <= ctrl;
      mag_q[wr_ptr_q]  <= mag;
    end
  end

endmodule

FILE: design/itrd_back.sv
// ----------------------------------------------------------------------------
// itrd_back: digit generation and character output
// Divides the magnitude by the base eight quotient bits per cycle, pushes each
// remainder onto a digit stack and pops the stack most significant first into
// a registered output stage.
// ----------------------------------------------------------------------------
module itrd_back #(
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  itrd_pkg::q_ctrl_t     q_ctrl_i,
  input  logic [VALUE_BITS-1:0] q_mag_i,
  itrd_out_if.source            out_o
);

  localparam int STEP   = itrd_pkg::STEP_BITS;
  localparam int CHUNKS = (VALUE_BITS + STEP - 1) / STEP;
  localparam int WP     = CHUNKS * STEP;
  localparam int KW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CW     = $clog2(VALUE_BITS + 1);
  localparam int DW     = itrd_pkg::DIGIT_W;

  itrd_pkg::back_state_e state_q, state_d;

  logic [WP-1:0]               work_q, work_d;
  logic [DW-1:0]               rem_q, rem_d;
  logic [itrd_pkg::BASE_W-1:0] base_q, base_d;
  logic                        neg_q, neg_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [KW-1:0]               chunk_q, chunk_d;
  logic [DW-1:0]               stack_q [VALUE_BITS];
  logic [DW-1:0]               stack_d [VALUE_BITS];

  logic                        out_valid_q, out_valid_d;
  logic [itrd_pkg::CHAR_W-1:0] char_q, char_d;
  logic                        last_q, last_d;
  logic                        bad_q, bad_d;

  logic                        slot_free;
  logic [DW:0]                 r;
  logic [STEP-1:0]             qb;
  logic [WP-1:0]               quot;

  assign slot_free   = !out_valid_q || out_o.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.last      = last_q;
  assign out_o.bad_base  = bad_q;

  always_comb begin
    r  = {1'b0, rem_q};
    qb = '0;
    for (int j = 0; j < STEP; j++) begin
      r = {r[DW-1:0], work_q[WP-1-j]};
      if (r >= {1'b0, base_q}) begin
        r = r - {1'b0, base_q};
        qb[STEP-1-j] = 1'b1;
      end
    end
    quot = (work_q << STEP) | WP'(qb);
  end

  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    rem_d       = rem_q;
    base_d      = base_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    chunk_d     = chunk_q;
    stack_d     = stack_q;
    out_valid_d = out_valid_q && !out_o.ready;
    char_d      = char_q;
    last_d      = last_q;
    bad_d       = bad_q;
    q_ready_o   = 1'b0;

    unique case (state_q)
      itrd_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          if (q_ctrl_i.bad) begin
            if (slot_free) begin
              q_ready_o   = 1'b1;
              out_valid_d = 1'b1;
              char_d      = itrd_pkg::INVALID_CODE;
              last_d      = 1'b1;
              bad_d       = 1'b1;
            end
          end else begin
            q_ready_o = 1'b1;
            work_d    = WP'(q_mag_i);
            rem_d     = '0;
            base_d    = q_ctrl_i.base;
            neg_d     = q_ctrl_i.neg;
            cnt_d     = '0;
            chunk_d   = '0;
            state_d   = itrd_pkg::BK_DIV;
          end
        end
      end
      itrd_pkg::BK_DIV: begin
        work_d = quot;
        rem_d  = r[DW-1:0];
        if (chunk_q == KW'(CHUNKS - 1)) begin
          stack_d[0] = r[DW-1:0];
          for (int i = 1; i < VALUE_BITS; i++) begin
            stack_d[i] = stack_q[i-1];
          end
          cnt_d   = cnt_q + CW'(1);
          chunk_d = '0;
          rem_d   = '0;
          if (quot == '0) begin
            state_d = itrd_pkg::BK_EMIT;
          end
        end else begin
          chunk_d = chunk_q + KW'(1);
        end
      end
      itrd_pkg::BK_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          bad_d       = 1'b0;
          if (neg_q) begin
            char_d = itrd_pkg::MINUS_CODE;
            last_d = 1'b0;
            neg_d  = 1'b0;
          end else begin
            char_d = itrd_pkg::digit_char(stack_q[0]);
            last_d = (cnt_q == CW'(1));
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
              stack_d[i] = stack_q[i+1];
            end
            cnt_d = cnt_q - CW'(1);
            if (cnt_q == CW'(1)) begin
              state_d = itrd_pkg::BK_IDLE;
            end
          end
        end
      end
      default: state_d = itrd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itrd_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    rem_q   <= rem_d;
    base_q  <= base_d;
    neg_q   <= neg_d;
    cnt_q   <= cnt_d;
    chunk_q <= chunk_d;
    stack_q <= stack_d;
    char_q  <= char_d;
    last_q  <= last_d;
    bad_q   <= bad_d;
  end

endmodule

FILE: design/integer_to_radix_digits_top.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top: integer to ASCII digit string converter
// Converts a value to its digits in a base from 2 to 36, one character per
// output transaction, most significant digit first.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction on in_ch_i carries op (signed mode), value and base.
// Each character leaves as one transaction on out_ch_o; last marks the final
// character of a conversion. A base outside 2 to 36 gives one transaction
// with char_code 0, last and bad_base set. Signed mode with base 10 and a
// negative value gives a leading minus sign.
// The front end classifies a request in the cycle it is taken and holds up to
// two requests, so requests keep flowing while the back end works.
// The back end divides by the base eight quotient bits per cycle, working
// through the magnitude in 8-bit chunks for each digit, and only then sends the
// characters from its digit stack; it takes the next request once the last
// character of the current one has been sent.
// A stalled receiver holds the registered output character and halts the
// back end's character output; the front queue fills and in_ch_i.ready drops.
// Reset clears the queue, the output stage and the back end state machine.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_top #(
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itrd_in_if.sink     in_ch_i,
  itrd_out_if.source  out_ch_o
);

  logic                  q_valid;
  logic                  q_ready;
  itrd_pkg::q_ctrl_t     q_ctrl;
  logic [VALUE_BITS-1:0] q_mag;

  itrd_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ch_i.ready),
    .in_op_i    (in_ch_i.op),
    .in_value_i (in_ch_i.value),
    .in_base_i  (in_ch_i.base),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_ctrl_o   (q_ctrl),
    .q_mag_o    (q_mag)
  );

  itrd_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_ctrl_i  (q_ctrl),
    .q_mag_i   (q_mag),
    .out_o     (out_ch_o)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for integer_to_radix_digits_top
// Sends conversion requests over the input channel and predicts the digit
// string of each one. Every character transaction that leaves the block is
// compared field by field with the oldest predicted character. Both channels
// idle and stall at random, and the run checks directed corner cases, a pause
// until the block drains, and a long stretch of random requests.
// ----------------------------------------------------------------------------
module tb;

  localparam int          NUM_BITS    = itrd_pkg::VALUE_BITS_DEF;
  localparam logic        OP_UNSIGNED = 1'b0;
  localparam logic        OP_SIGNED   = 1'b1;
  localparam int          NUM_RANDOM  = 70;
  localparam int          TAIL_CYCLES = 200;
  localparam int          CYCLE_LIMIT = 400000;
  localparam string       DIGIT_SET   = "0123456789abcdefghijklmnopqrstuvwxyz";

  typedef struct packed {
    logic [itrd_pkg::CHAR_W-1:0] char_code;
    logic                        last;
    logic                        bad_base;
  } char_rec_t;

  logic clk_i;
  logic rst_ni;
  logic idle_en;
  int   error_count;
  int   cycle_count;
  int   requests_sent;
  int   chars_checked;

  char_rec_t pending_chars[$];

  itrd_in_if  in_ch ();
  itrd_out_if out_ch ();

  integer_to_radix_digits_top #(
    .VALUE_BITS(NUM_BITS)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void predict_digits(input logic op,
                                         input logic [itrd_pkg::VALUE_W-1:0] value,
                                         input logic [itrd_pkg::BASE_W-1:0] base);
    logic [itrd_pkg::VALUE_W-1:0] mag;
    logic [itrd_pkg::VALUE_W-1:0] radix;
    logic [itrd_pkg::VALUE_W-1:0] rem;
    logic [itrd_pkg::CHAR_W-1:0]  rev[$];
    logic                         neg;
    char_rec_t                    rec;
    if (base < itrd_pkg::RADIX_MIN || base > itrd_pkg::RADIX_MAX) begin
      rec = '{char_code: itrd_pkg::INVALID_CODE, last: 1'b1, bad_base: 1'b1};
      pending_chars.push_back(rec);
      return;
    end
    radix = itrd_pkg::VALUE_W'(base);
    neg = (op == OP_SIGNED) && (base == itrd_pkg::SIGNED_RADIX) && value[NUM_BITS-1];
    mag = neg ? (~value + 1'b1) : value;
    rem = mag % radix;
    rev.push_back(itrd_pkg::CHAR_W'(DIGIT_SET[rem]));
    mag = mag / radix;
    while (mag != '0) begin
      rem = mag % radix;
      rev.push_back(itrd_pkg::CHAR_W'(DIGIT_SET[rem]));
      mag = mag / radix;
    end
    if (neg) begin
      rec = '{char_code: itrd_pkg::MINUS_CODE, last: 1'b0, bad_base: 1'b0};
      pending_chars.push_back(rec);
    end
    for (int i = rev.size() - 1; i >= 0; i--) begin
      rec = '{char_code: rev[i], last: (i == 0), bad_base: 1'b0};
      pending_chars.push_back(rec);
    end
  endfunction

  task automatic send_request(input logic op, input logic [itrd_pkg::VALUE_W-1:0] value,
                              input logic [itrd_pkg::BASE_W-1:0] base);
    int gap;
    gap = idle_en ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid = 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid = 1'b1;
    in_ch.op    = op;
    in_ch.value = value;
    in_ch.base  = base;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_digits(op, value, base);
    requests_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [itrd_pkg::VALUE_W-1:0] pick_value();
    logic [itrd_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 6))
      0:       v = itrd_pkg::VALUE_W'($urandom_range(0, 40));
      1:       v = '1;
      2:       v = {1'b1, {(itrd_pkg::VALUE_W-1){1'b0}}};
      3:       v = {1'b0, {(itrd_pkg::VALUE_W-1){1'b1}}};
      4:       v = itrd_pkg::VALUE_W'($urandom) >> $urandom_range(0, itrd_pkg::VALUE_W - 1);
      default: v = itrd_pkg::VALUE_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [itrd_pkg::BASE_W-1:0] pick_base();
    logic [itrd_pkg::BASE_W-1:0] b;
    case ($urandom_range(0, 9))
      0:       b = itrd_pkg::BASE_W'($urandom_range(0, 63));
      1:       b = itrd_pkg::SIGNED_RADIX;
      2:       b = itrd_pkg::RADIX_MAX;
      3:       b = itrd_pkg::RADIX_MIN;
      default: b = itrd_pkg::BASE_W'($urandom_range(itrd_pkg::RADIX_MIN,
                                                    itrd_pkg::RADIX_MAX));
    endcase
    return b;
  endfunction

  task automatic test_directed();
    send_request(OP_UNSIGNED, '0, itrd_pkg::SIGNED_RADIX);
    send_request(OP_SIGNED, '0, itrd_pkg::SIGNED_RADIX);
    send_request(OP_UNSIGNED, '1, itrd_pkg::RADIX_MIN);
    send_request(OP_UNSIGNED, '1, itrd_pkg::RADIX_MAX);
    send_request(OP_UNSIGNED, '1, itrd_pkg::SIGNED_RADIX);
    send_request(OP_SIGNED, '1, itrd_pkg::SIGNED_RADIX);
    send_request(OP_SIGNED, 32'h8000_0000, itrd_pkg::SIGNED_RADIX);
    send_request(OP_SIGNED, 32'h7FFF_FFFF, itrd_pkg::SIGNED_RADIX);
    send_request(OP_SIGNED, 32'h8000_0000, 6'd16);
    send_request(OP_SIGNED, 32'hDEAD_BEEF, itrd_pkg::RADIX_MIN);
    send_request(OP_SIGNED, 32'hFFFF_FFF6, 6'd36);
    send_request(OP_UNSIGNED, 32'd1, itrd_pkg::RADIX_MIN);
    send_request(OP_UNSIGNED, 32'd35, itrd_pkg::RADIX_MAX);
    send_request(OP_UNSIGNED, 32'd36, itrd_pkg::RADIX_MAX);
    send_request(OP_UNSIGNED, 32'd255, 6'd16);
    send_request(OP_UNSIGNED, 32'd12345, 6'd8);
    send_request(OP_UNSIGNED, 32'd7, 6'd0);
    send_request(OP_SIGNED, '1, 6'd1);
    send_request(OP_UNSIGNED, 32'h8000_0000, 6'd37);
    send_request(OP_SIGNED, 32'h5555_5555, 6'd63);
    send_request(OP_UNSIGNED, 32'hAAAA_AAAA, 6'd3);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 4; i++) begin
      send_request(logic'($urandom_range(0, 1)), pick_value(), pick_base());
    end
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      send_request(logic'($urandom_range(0, 1)), pick_value(), pick_base());
    end
    wait_drained();
  endtask

  task automatic test_random();
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 20 == 0) idle_en = ($urandom_range(0, 2) != 0);
      send_request(logic'($urandom_range(0, 1)), pick_value(), pick_base());
    end
    wait_drained();
  endtask

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_en ? $urandom_range(0, 4) : 0;
      repeat (stall) begin
        @(negedge clk_i);
        out_ch.ready = 1'b0;
      end
      @(negedge clk_i);
      out_ch.ready = 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    char_rec_t exp_rec;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%0h", out_ch.char_code));
      end else begin
        exp_rec = pending_chars.pop_front();
        chars_checked++;
        if (out_ch.char_code !== exp_rec.char_code) begin
          report_mismatch($sformatf("char_code 0x%0h, expected 0x%0h",
                                    out_ch.char_code, exp_rec.char_code));
        end
        if (out_ch.last !== exp_rec.last) begin
          report_mismatch($sformatf("last %0b, expected %0b", out_ch.last, exp_rec.last));
        end
        if (out_ch.bad_base !== exp_rec.bad_base) begin
          report_mismatch($sformatf("bad_base %0b, expected %0b",
                                    out_ch.bad_base, exp_rec.bad_base));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    error_count   = 0;
    requests_sent = 0;
    chars_checked = 0;
    idle_en       = 1'b1;
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_UNSIGNED;
    in_ch.value   = '0;
    in_ch.base    = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_drain_pause();
    test_random();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
    end
    $display("tb: %0d requests converted, %0d characters checked, %0d mismatches",
             requests_sent, chars_checked, error_count);
    $display("tb: covered zero, extreme values, signed decimal, invalid bases and stalls");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
design/itrd_pkg.sv
design/itrd_if.sv
design/itrd_front.sv
design/itrd_back.sv
design/integer_to_radix_digits_top.sv
tb/tb.sv
